### src/sem_pkg.sv
`default_nettype none
package sem_pkg;

  localparam int MaxLineWidth = 1024;
  localparam int ChannelLanes = 4;
  localparam int MaxFrameHeight = 4096;

  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef struct packed {
    logic [7:0] in_ch3;
    logic [7:0] in_ch2;
    logic [7:0] in_ch1;
    logic [7:0] in_ch0;
  } sem_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  out_ch0;
    logic [7:0]  out_ch1;
    logic [7:0]  out_ch2;
    logic [7:0]  out_ch3;
    logic        last_result;
  } sem_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_ROOT,
    ST_EMIT_INT,
    ST_EMIT_BRD
  } sem_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic calc;
    logic root_start;
    logic root_step;
    logic commit;
    logic show_int;
    logic show_brd;
    logic show_last;
  } sem_cmd_t;

  typedef struct packed {
    logic has_int;
    logic has_brd;
    logic root_done;
  } sem_status_t;

endpackage
`default_nettype wire

### src/sem_ctrl.sv
`default_nettype none
module sem_ctrl import sem_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        out_stall,
  input  sem_status_t      status,
  output logic             in_stall,
  output logic             out_valid,
  output sem_cmd_t         cmd
);

  sem_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_CALC;
      ST_CALC: begin
        if (status.has_int) state_next = ST_ROOT;
        else if (status.has_brd) state_next = ST_EMIT_BRD;
        else state_next = ST_IDLE;
      end
      ST_ROOT: begin
        if (status.root_done) state_next = ST_EMIT_INT;
      end
      ST_EMIT_INT: begin
        if (!out_stall) state_next = status.has_brd ? ST_EMIT_BRD : ST_IDLE;
      end
      ST_EMIT_BRD: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ: cmd.read = 1'b1;
      ST_CALC: begin
        cmd.calc = 1'b1;
        cmd.root_start = status.has_int;
        cmd.commit = 1'b1;
      end
      ST_ROOT: cmd.root_step = 1'b1;
      ST_EMIT_INT: begin
        out_valid = 1'b1;
        cmd.show_int = 1'b1;
        cmd.show_last = !status.has_brd;
      end
      ST_EMIT_BRD: begin
        out_valid = 1'b1;
        cmd.show_brd = 1'b1;
        cmd.show_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/sem_dp.sv
`default_nettype none
module sem_dp import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MaxLineWidth,
  parameter int CHANNEL_LANES = ChannelLanes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  sem_in_t          in_data,
  input  sem_cmd_t         cmd,
  output sem_status_t      status,
  output sem_out_t         out_data
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);

  logic [31:0] upper_mem [MAX_LINE_WIDTH];
  logic [31:0] middle_mem [MAX_LINE_WIDTH];
  logic [31:0] top, mid, cur;
  logic [31:0] win [6];
  logic [10:0] line_width;
  logic [12:0] frame_height;
  logic [2:0]  channel_count;
  logic [11:0] row;
  logic [9:0]  col;
  logic has_int, has_brd;

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [2:0]    n_eff;
  logic [AW-1:0] addr;

  always_comb begin
    if (line_width == 11'd0) w_eff = WW'(1);
    else if (32'(line_width) > MAX_LINE_WIDTH) w_eff = WW'(MAX_LINE_WIDTH);
    else w_eff = WW'(line_width);
    if (frame_height == 13'd0) h_eff = 13'd1;
    else if (frame_height > 13'(MaxFrameHeight)) h_eff = 13'(MaxFrameHeight);
    else h_eff = frame_height;
    if (channel_count == 3'd0) n_eff = 3'd1;
    else if (32'(channel_count) > CHANNEL_LANES) n_eff = 3'(CHANNEL_LANES);
    else n_eff = channel_count;
  end

  logic [WW-1:0] col_e;
  logic [12:0]   row_e;
  assign col_e = (WW'(col) >= w_eff) ? '0 : WW'(col);
  assign row_e = ({1'b0, row} >= h_eff) ? '0 : {1'b0, row};
  assign addr = AW'(col_e);

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_data;
    if (cmd.read) begin
      top <= upper_mem[addr];
      mid <= middle_mem[addr];
    end
    if (cmd.commit) begin
      upper_mem[addr] <= mid;
      middle_mem[addr] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 11'd640;
      frame_height <= 13'd480;
      channel_count <= 3'd1;
      row <= '0;
      col <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
      has_int <= 1'b0;
      has_brd <= 1'b0;
    end else begin
      if (cmd.read) begin
        has_int <= (row_e >= 13'd2) && (col_e >= WW'(2));
        has_brd <= (row_e == 13'd0) || (row_e == h_eff - 13'd1) ||
                   (col_e == '0) || (col_e == w_eff - WW'(1));
      end
      if (cmd.commit) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top;
        win[4] <= mid;
        win[5] <= cur;
        if (col_e + WW'(1) >= w_eff) begin
          col <= '0;
          row <= (row_e + 13'd1 >= h_eff) ? 12'd0 : 12'(row_e + 13'd1);
        end else begin
          col <= 10'(col_e + WW'(1));
          row <= 12'(row_e);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_LINE_WIDTH: begin
            line_width <= cfg_data[10:0];
            row <= '0;
            col <= '0;
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data;
            row <= '0;
            col <= '0;
          end
          REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // position and channel snapshot of the item at work
  logic [11:0] p_row;
  logic [9:0]  p_col;
  logic [31:0] p_cur;
  logic [16:0] sq [4];
  logic [7:0]  root [4];
  logic [7:0]  bitm;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      p_row <= 12'(row_e);
      p_col <= 10'(col_e);
    end
    if (cmd.calc) begin
      p_cur <= cur;
      for (int c = 0; c < 4; c++) begin
        logic signed [11:0] gx, gy;
        logic [7:0] q0, q1, q2, q3, q5, q6, q7, q8;
        q0 = win[0][8*c +: 8]; q3 = win[1][8*c +: 8]; q6 = win[2][8*c +: 8];
        q1 = win[3][8*c +: 8]; q7 = win[5][8*c +: 8];
        q2 = top[8*c +: 8]; q5 = mid[8*c +: 8]; q8 = cur[8*c +: 8];
        gx = (12'(q2) + 12'(q5) * 12'sd2 + 12'(q8)) - (12'(q0) + 12'(q3) * 12'sd2 + 12'(q6));
        gy = (12'(q6) + 12'(q7) * 12'sd2 + 12'(q8)) - (12'(q0) + 12'(q1) * 12'sd2 + 12'(q2));
        sq[c] <= 17'($unsigned(22'(gx * gx)) + $unsigned(22'(gy * gy)) > 22'd65535
                     ? 17'h10000 : 17'(gx * gx + gy * gy));
        root[c] <= '0;
      end
      bitm <= 8'h80;
    end else if (cmd.root_step) begin
      for (int c = 0; c < 4; c++) begin
        logic [7:0] t;
        t = root[c] | bitm;
        if (sq[c][16]) root[c] <= 8'hff;
        else if (17'(16'(t) * 16'(t)) <= sq[c]) root[c] <= t;
      end
      bitm <= bitm >> 1;
    end
  end

  assign status.has_int = has_int;
  assign status.has_brd = has_brd;
  assign status.root_done = cmd.root_step && bitm == 8'h01;

  logic [7:0] oc [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (32'(c) >= 32'(n_eff)) oc[c] = '0;
      else if (cmd.show_int) oc[c] = root[c];
      else oc[c] = p_cur[8*c +: 8];
    end
    out_data.out_row = cmd.show_int ? p_row - 12'd1 : p_row;
    out_data.out_col = cmd.show_int ? p_col - 10'd1 : p_col;
    out_data.out_ch0 = oc[0];
    out_data.out_ch1 = oc[1];
    out_data.out_ch2 = oc[2];
    out_data.out_ch3 = oc[3];
    out_data.last_result = cmd.show_last;
  end

endmodule
`default_nettype wire

### src/sobel_edge_magnitude.sv
`default_nettype none
// Sobel 3x3 edge magnitude over a raster frame, up to four 8-bit channels per
// pixel. A request may yield nothing, only a border pass-through, an interior
// result, or an interior result and a border pass-through. The block takes no
// new request until it is through with the last one. Its steps are a read of
// the two line memories, a gradient step, the bit-serial square root of each
// channel for an interior result, and the emission of each result, which
// output stall can hold. Results leave with last_result set on the final one
// of each request, the interior result ahead of the border pass-through.
module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MaxLineWidth,
  parameter int CHANNEL_LANES = ChannelLanes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  sem_in_t          in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output sem_out_t         out_data
);

  sem_cmd_t    cmd;
  sem_status_t status;

  sem_ctrl u_ctrl (
    .clk, .rst, .in_valid, .out_stall, .status, .in_stall, .out_valid, .cmd
  );

  sem_dp #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH), .CHANNEL_LANES(CHANNEL_LANES)
  ) u_dp (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_data, .cmd, .status,
    .out_data
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("accept during emit");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_result |=> out_valid)
    else $error("second result missing");

endmodule
`default_nettype wire
